// ===== rtl/smbrw_pkg.sv =====
// shared types, codes and helper functions of the smbus read-word master
`timescale 1ns / 1ps

package smbrw_pkg;

    localparam int SlaveAddrW = 7;
    localparam int TicksW     = 16;
    localparam int AttemptsW  = 8;
    localparam int CfgDataW   = 16;
    localparam int CfgIndexW  = 2;
    localparam int InDataW    = 16;
    localparam int OutDataW   = 24;
    localparam int BitIdxW    = 4;
    localparam int PhaseW     = 2;

    localparam logic [7:0]         CrcPoly  = 8'h07;
    localparam logic [BitIdxW-1:0] AckBit   = 4'd8;
    localparam logic [PhaseW-1:0]  PhaseSet = 2'd0;
    localparam logic [PhaseW-1:0]  PhaseHi  = 2'd1;
    localparam logic [PhaseW-1:0]  PhaseLo  = 2'd2;
    localparam logic [PhaseW-1:0]  PhaseEnd = 2'd3;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] RegSlaveAddr    = 2'd0;
    localparam logic [CfgIndexW-1:0] RegTicksPerPhase = 2'd1;
    localparam logic [CfgIndexW-1:0] RegMaxAttempts  = 2'd2;

    // input item kinds
    localparam logic OpTick    = 1'b0;
    localparam logic OpRequest = 1'b1;

    typedef enum logic [10:0] {
        SEQ_IDLE     = 11'b000_0000_0001,
        SEQ_STOP     = 11'b000_0000_0010,
        SEQ_START1   = 11'b000_0000_0100,
        SEQ_TX_ADDRW = 11'b000_0000_1000,
        SEQ_TX_CMD   = 11'b000_0001_0000,
        SEQ_START2   = 11'b000_0010_0000,
        SEQ_TX_ADDRR = 11'b000_0100_0000,
        SEQ_RX_LOW   = 11'b000_1000_0000,
        SEQ_RX_HIGH  = 11'b001_0000_0000,
        SEQ_RX_PEC   = 11'b010_0000_0000,
        SEQ_FINSTOP  = 11'b100_0000_0000
    } seq_t;

    typedef struct packed {
        logic [SlaveAddrW-1:0] slave_address;
        logic [TicksW-1:0]     ticks_per_phase;
        logic [AttemptsW-1:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [15:0] read_word;
        logic        failed;
        logic        done_res;
        logic        busy_res;
        logic        sda_out;
        logic        scl_out;
    } res_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } drive_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic seg_is_cond(input seq_t s);
        return (s == SEQ_STOP) || (s == SEQ_FINSTOP) || (s == SEQ_START1) || (s == SEQ_START2);
    endfunction

    function automatic logic seg_is_tx(input seq_t s);
        return (s == SEQ_TX_ADDRW) || (s == SEQ_TX_CMD) || (s == SEQ_TX_ADDRR);
    endfunction

    // line drives set on entry to a phase
    function automatic drive_t phase_drive(input seq_t s, input logic [PhaseW-1:0] ph,
                                           input logic [BitIdxW-1:0] bidx,
                                           input logic [7:0] sh, input drive_t cur);
        drive_t d;
        d = cur;
        case (s)
            SEQ_STOP, SEQ_FINSTOP:
            begin
                case (ph)
                    PhaseSet: d.scl = 1'b0;
                    PhaseHi:  d.sda = 1'b0;
                    PhaseLo:  d.scl = 1'b1;
                    default:  d.sda = 1'b1;
                endcase
            end
            SEQ_START1, SEQ_START2:
            begin
                case (ph)
                    PhaseSet: d.sda = 1'b1;
                    PhaseHi:  d.scl = 1'b1;
                    PhaseLo:  d.sda = 1'b0;
                    default:  d.scl = 1'b0;
                endcase
            end
            SEQ_IDLE:
            begin
                d = cur;
            end
            default:
            begin
                if (ph == PhaseSet) begin
                    if (seg_is_tx(s)) begin
                        d.sda = (bidx < AckBit) ? sh[7] : 1'b1;
                    end else begin
                        // master acks low and high bytes, nacks the pec byte
                        d.sda = (bidx < AckBit) ? 1'b1 : (s == SEQ_RX_PEC);
                    end
                end else if (ph == PhaseHi) begin
                    d.scl = 1'b1;
                end else begin
                    d.scl = 1'b0;
                end
            end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/smbrw_engine.sv =====
// transaction sequencer: bit timing, byte shifting, pec check and retries
`timescale 1ns / 1ps

module smbrw_engine
    import smbrw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       op,
    input  logic [7:0] command,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output res_t       res
);

    seq_t                 seq_reg, seq_next;
    logic [TicksW-1:0]    tick_reg, tick_next;
    logic [BitIdxW-1:0]   bit_reg, bit_next;
    logic [PhaseW-1:0]    phase_reg, phase_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           low_reg, low_next;
    logic [7:0]           high_reg, high_next;
    logic [7:0]           pec_reg, pec_next;
    logic [AttemptsW-1:0] attempts_reg, attempts_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic                 nack_reg, nack_next;
    drive_t               drv_reg, drv_next;

    logic [TicksW-1:0]    len;
    logic [TicksW-1:0]    tick_inc;
    logic [PhaseW:0]      ph_inc;
    logic                 cond;
    logic                 tx;
    logic                 seg_end;
    logic                 do_apply;
    logic                 fin_ok;
    logic                 fin_fail;
    logic [7:0]           addr_w;

    always_comb
    begin
        seq_next      = seq_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        pec_next      = pec_reg;
        attempts_next = attempts_reg;
        cmd_next      = cmd_reg;
        nack_next     = nack_reg;
        drv_next      = drv_reg;
        do_apply      = 1'b0;
        fin_ok        = 1'b0;
        fin_fail      = 1'b0;
        seg_end       = 1'b0;
        len           = (cfg.ticks_per_phase == '0) ? TicksW'(1) : cfg.ticks_per_phase;
        tick_inc      = tick_reg + TicksW'(1);
        ph_inc        = {1'b0, phase_reg} + (PhaseW + 1)'(1);
        cond          = seg_is_cond(seq_reg);
        tx            = seg_is_tx(seq_reg);
        addr_w        = {cfg.slave_address, 1'b0};

        if (step) begin
            if (op == OpRequest) begin
                if (seq_reg == SEQ_IDLE) begin
                    cmd_next      = command;
                    attempts_next = cfg.max_attempts;
                    low_next      = '0;
                    high_next     = '0;
                    pec_next      = '0;
                    shift_next    = '0;
                    tick_next     = '0;
                    seq_next      = SEQ_STOP;
                    phase_next    = PhaseSet;
                    bit_next      = '0;
                    nack_next     = 1'b0;
                    do_apply      = 1'b1;
                end
            end else if (seq_reg != SEQ_IDLE) begin
                if (tick_inc >= len) begin
                    tick_next = '0;
                    if (!cond) begin
                        if (phase_reg == PhaseHi) begin
                            // sample at the end of scl high
                            if (bit_reg >= AckBit) begin
                                if (tx) begin
                                    nack_next = sda_in;
                                end
                            end else if (!tx) begin
                                shift_next = {shift_reg[6:0], sda_in};
                            end
                        end else if (phase_reg == PhaseLo && bit_reg < AckBit && tx) begin
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                    end
                    if (ph_inc < (cond ? (PhaseW + 1)'(4) : (PhaseW + 1)'(3))) begin
                        phase_next = ph_inc[PhaseW-1:0];
                        do_apply   = 1'b1;
                    end else begin
                        seg_end = 1'b1;
                        if (!cond) begin
                            bit_next = bit_reg + BitIdxW'(1);
                            if (bit_next <= AckBit) begin
                                phase_next = PhaseSet;
                                do_apply   = 1'b1;
                                seg_end    = 1'b0;
                            end else if (tx && nack_next) begin
                                seq_next   = SEQ_STOP;
                                phase_next = PhaseSet;
                                bit_next   = '0;
                                nack_next  = 1'b0;
                                do_apply   = 1'b1;
                                seg_end    = 1'b0;
                            end
                        end
                    end
                    if (seg_end) begin
                        phase_next = PhaseSet;
                        bit_next   = '0;
                        nack_next  = 1'b0;
                        do_apply   = 1'b1;
                        case (seq_reg)
                            SEQ_STOP:
                            begin
                                if (attempts_reg == '0) begin
                                    seq_next = SEQ_IDLE;
                                    drv_next = '{scl: 1'b1, sda: 1'b1};
                                    do_apply = 1'b0;
                                    fin_fail = 1'b1;
                                end else begin
                                    attempts_next = attempts_reg - AttemptsW'(1);
                                    pec_next      = '0;
                                    seq_next      = SEQ_START1;
                                end
                            end
                            SEQ_START1:
                            begin
                                shift_next = addr_w;
                                pec_next   = crc8_byte(pec_reg, addr_w);
                                seq_next   = SEQ_TX_ADDRW;
                            end
                            SEQ_TX_ADDRW:
                            begin
                                shift_next = cmd_reg;
                                pec_next   = crc8_byte(pec_reg, cmd_reg);
                                seq_next   = SEQ_TX_CMD;
                            end
                            SEQ_TX_CMD:
                            begin
                                seq_next = SEQ_START2;
                            end
                            SEQ_START2:
                            begin
                                shift_next = addr_w | 8'h01;
                                pec_next   = crc8_byte(pec_reg, addr_w | 8'h01);
                                seq_next   = SEQ_TX_ADDRR;
                            end
                            SEQ_TX_ADDRR:
                            begin
                                seq_next = SEQ_RX_LOW;
                            end
                            SEQ_RX_LOW:
                            begin
                                low_next = shift_next;
                                pec_next = crc8_byte(pec_reg, shift_next);
                                seq_next = SEQ_RX_HIGH;
                            end
                            SEQ_RX_HIGH:
                            begin
                                high_next = shift_next;
                                pec_next  = crc8_byte(pec_reg, shift_next);
                                seq_next  = SEQ_RX_PEC;
                            end
                            SEQ_RX_PEC:
                            begin
                                seq_next = SEQ_FINSTOP;
                            end
                            default:
                            begin
                                // closing stop: good pec ends, bad pec retries
                                if (pec_reg == shift_reg) begin
                                    seq_next = SEQ_IDLE;
                                    drv_next = '{scl: 1'b1, sda: 1'b1};
                                    do_apply = 1'b0;
                                    fin_ok   = 1'b1;
                                end else begin
                                    seq_next = SEQ_STOP;
                                end
                            end
                        endcase
                    end
                end else begin
                    tick_next = tick_inc;
                end
            end
        end

        if (do_apply) begin
            drv_next = phase_drive(seq_next, phase_next, bit_next, shift_next, drv_reg);
        end

        res.scl_out   = drv_next.scl;
        res.sda_out   = drv_next.sda;
        res.busy_res  = (seq_next != SEQ_IDLE);
        res.done_res  = fin_ok | fin_fail;
        res.failed    = fin_fail;
        res.read_word = {high_next, low_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg      <= SEQ_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            phase_reg    <= PhaseSet;
            shift_reg    <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            pec_reg      <= '0;
            attempts_reg <= '0;
            cmd_reg      <= '0;
            nack_reg     <= 1'b0;
            drv_reg      <= '{scl: 1'b1, sda: 1'b1};
        end else begin
            seq_reg      <= seq_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            pec_reg      <= pec_next;
            attempts_reg <= attempts_next;
            cmd_reg      <= cmd_next;
            nack_reg     <= nack_next;
            drv_reg      <= drv_next;
        end
    end

    // bit counter covers eight data bits and the ack slot only
    assert property (@(posedge clk) disable iff (!rst_n) bit_reg <= AckBit)
        else $error("bit index past ack slot");

    // bit segments use three phases
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SEQ_IDLE && !seg_is_cond(seq_reg)) |-> phase_reg != PhaseEnd)
        else $error("fourth phase in a bit segment");

    // both lines released whenever the bus is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_IDLE |-> (drv_reg.scl && drv_reg.sda))
        else $error("line pulled low while idle");

endmodule

// ===== rtl/smbus_read_word_pec_master_core.sv =====
// top level: stream handshake, configuration registers and result register
`timescale 1ns / 1ps

// smbus read-word master with pec, driven by a stream of tick and request items
//
// input stream: s_axis_tuser is the item kind (0 = one timebase tick,
// 1 = read request); s_axis_tdata carries the command byte and the sampled
// sda level. every input item yields exactly one result item on the output
// stream: line drives (1 = release), busy, a one-item done pulse, failed and
// the last received word.
// an item accepted at an edge has its result in the output register from that edge on.
// one item per cycle is sustained while the receiver is ready, since the sequencer step
// is a single pass of logic between the state registers.
// when the receiver stalls, the output register holds its result and the
// input side takes a new item only in the same cycle the held one leaves.
// the bus timing is counted in items: each phase lasts ticks_per_phase ticks (0 counts as 1).
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. reset releases both lines, empties the output
// register and sets slave_address 0, ticks_per_phase 8, max_attempts 255.

module smbus_read_word_pec_master_core
    import smbrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [InDataW-1:0]   s_axis_tdata,  // command[7:0], sda_in[8], zero pad
    input  logic                 s_axis_tuser,  // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OutDataW-1:0]  m_axis_tdata,  // scl_out, sda_out, busy_res, done_res,
                                                // failed, read_word[15:0], zero pad
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    cfg_t                cfg_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic                accept;
    res_t                step_res;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    smbrw_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .op      (s_axis_tuser),
        .command (s_axis_tdata[7:0]),
        .sda_in  (s_axis_tdata[8]),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.slave_address   <= '0;
            cfg_reg.ticks_per_phase <= TicksW'(8);
            cfg_reg.max_attempts    <= AttemptsW'(255);
        end else if (cfg_we) begin
            case (cfg_index)
                RegSlaveAddr:     cfg_reg.slave_address   <= cfg_data[SlaveAddrW-1:0];
                RegTicksPerPhase: cfg_reg.ticks_per_phase <= cfg_data[TicksW-1:0];
                RegMaxAttempts:   cfg_reg.max_attempts    <= cfg_data[AttemptsW-1:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OutDataW - $bits(res_t))'(0), out_res_reg};

    // failure is only ever reported together with done
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!out_res_reg.failed || out_res_reg.done_res))
        else $error("failed without done");

    // the item that ends a transaction shows the bus idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.done_res) |->
            (!out_res_reg.busy_res && out_res_reg.scl_out && out_res_reg.sda_out))
        else $error("done while still busy");

    // a held result stays put until the receiver takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the smbus read-word master with pec
`timescale 1ns / 1ps

module testbench;
    import smbrw_pkg::*;

    localparam int NoAcceptLimit = 2000;
    localparam int LongHold      = 300;

    typedef enum logic [1:0] {FinNone, FinOk, FinFail} finish_t;
    typedef enum logic [1:0] {PlanGood, PlanBadPec, PlanNack, PlanNoise} attempt_plan_t;

    typedef struct {
        logic       op;
        logic [7:0] cmd;
        logic       sda;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    // bus master state as predicted
    seq_t        bus_seg;
    int unsigned ph_ctr;
    logic [15:0] tick_ctr;
    logic [3:0]  bit_ctr;
    logic [7:0]  shreg;
    logic [7:0]  rx_lo;
    logic [7:0]  rx_hi;
    logic [7:0]  crc_acc;
    logic [7:0]  tries_left;
    logic [7:0]  cmd_hold;
    logic        nack_flag;
    logic        scl_q;
    logic        sda_q;
    logic [6:0]  cfg_addr;
    logic [15:0] cfg_tpp;
    logic [7:0]  cfg_tries;

    // what the emulated slave answers during the current attempt
    attempt_plan_t plan_kind;
    seq_t          plan_nack_at;
    logic [7:0]    plan_lo;
    logic [7:0]    plan_hi;
    logic [7:0]    plan_pec;

    res_t        bus_results_q[$];
    stim_row_t   row_q[$];
    int unsigned fault_count;
    int unsigned rx_hold;
    bit          tx_gaps_on;
    bit          rx_gaps_on;

    smbus_read_word_pec_master_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        repeat (8) c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
        return c;
    endfunction

    function automatic bit is_cond(input seq_t s);
        case (s)
            SEQ_STOP, SEQ_FINSTOP, SEQ_START1, SEQ_START2: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_tx(input seq_t s);
        case (s)
            SEQ_TX_ADDRW, SEQ_TX_CMD, SEQ_TX_ADDRR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic res_t result_of(input logic scl, input logic sda, input logic busy,
                                       input logic done, input logic failed,
                                       input logic [15:0] word);
        res_t r;
        r.scl_out   = scl;
        r.sda_out   = sda;
        r.busy_res  = busy;
        r.done_res  = done;
        r.failed    = failed;
        r.read_word = word;
        return r;
    endfunction

    // drives that appear on entry to the current phase
    function automatic void set_lines();
        case (bus_seg)
            SEQ_STOP, SEQ_FINSTOP:
            begin
                case (ph_ctr)
                    0: scl_q = 1'b0;
                    1: sda_q = 1'b0;
                    2: scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            SEQ_START1, SEQ_START2:
            begin
                case (ph_ctr)
                    0: sda_q = 1'b1;
                    1: scl_q = 1'b1;
                    2: sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            SEQ_IDLE: ;
            default:
            begin
                if (ph_ctr == 0) begin
                    if (is_tx(bus_seg)) begin
                        sda_q = (bit_ctr < 8) ? shreg[7] : 1'b1;
                    end else begin
                        // ack low and high, nack the pec byte
                        sda_q = (bit_ctr < 8) || (bus_seg == SEQ_RX_PEC);
                    end
                end else if (ph_ctr == 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void enter_seg(input seq_t s);
        bus_seg   = s;
        ph_ctr    = 0;
        bit_ctr   = 4'd0;
        nack_flag = 1'b0;
        set_lines();
    endfunction

    function automatic void enter_send(input seq_t s, input logic [7:0] value);
        shreg   = value;
        crc_acc = crc8_next(crc_acc, value);
        enter_seg(s);
    endfunction

    function automatic finish_t close_phase(input logic sda);
        seq_t       s;
        logic [7:0] addr_w;
        s      = bus_seg;
        addr_w = {cfg_addr, 1'b0};
        if (!is_cond(s)) begin
            if (ph_ctr == 1) begin
                if (bit_ctr >= 8) begin
                    if (is_tx(s)) nack_flag = sda;
                end else if (!is_tx(s)) begin
                    shreg = {shreg[6:0], sda};
                end
            end else if (ph_ctr == 2 && bit_ctr < 8 && is_tx(s)) begin
                shreg = shreg << 1;
            end
        end
        ph_ctr++;
        if (ph_ctr < (is_cond(s) ? 4 : 3)) begin
            set_lines();
            return FinNone;
        end
        if (!is_cond(s)) begin
            bit_ctr++;
            if (bit_ctr <= 8) begin
                ph_ctr = 0;
                set_lines();
                return FinNone;
            end
            if (is_tx(s) && nack_flag) begin
                enter_seg(SEQ_STOP);
                return FinNone;
            end
        end
        case (s)
            SEQ_STOP:
            begin
                if (tries_left == 8'd0) begin
                    bus_seg = SEQ_IDLE;
                    scl_q   = 1'b1;
                    sda_q   = 1'b1;
                    return FinFail;
                end
                tries_left--;
                crc_acc = 8'd0;
                enter_seg(SEQ_START1);
            end
            SEQ_START1:   enter_send(SEQ_TX_ADDRW, addr_w);
            SEQ_TX_ADDRW: enter_send(SEQ_TX_CMD, cmd_hold);
            SEQ_TX_CMD:   enter_seg(SEQ_START2);
            SEQ_START2:   enter_send(SEQ_TX_ADDRR, addr_w | 8'd1);
            SEQ_TX_ADDRR: enter_seg(SEQ_RX_LOW);
            SEQ_RX_LOW:
            begin
                rx_lo   = shreg;
                crc_acc = crc8_next(crc_acc, rx_lo);
                enter_seg(SEQ_RX_HIGH);
            end
            SEQ_RX_HIGH:
            begin
                rx_hi   = shreg;
                crc_acc = crc8_next(crc_acc, rx_hi);
                enter_seg(SEQ_RX_PEC);
            end
            SEQ_RX_PEC:   enter_seg(SEQ_FINSTOP);
            default:
            begin
                // closing stop: pec decides between done and a new attempt
                if (crc_acc == shreg) begin
                    bus_seg = SEQ_IDLE;
                    scl_q   = 1'b1;
                    sda_q   = 1'b1;
                    return FinOk;
                end
                enter_seg(SEQ_STOP);
            end
        endcase
        return FinNone;
    endfunction

    function automatic res_t master_step(input logic op, input logic [7:0] cmd,
                                         input logic sda);
        finish_t     fin;
        logic [15:0] len;
        fin = FinNone;
        if (op == OpRequest) begin
            if (bus_seg == SEQ_IDLE) begin
                cmd_hold   = cmd;
                tries_left = cfg_tries;
                rx_lo      = 8'd0;
                rx_hi      = 8'd0;
                crc_acc    = 8'd0;
                shreg      = 8'd0;
                tick_ctr   = 16'd0;
                enter_seg(SEQ_STOP);
            end
        end else if (bus_seg != SEQ_IDLE) begin
            len      = (cfg_tpp == 16'd0) ? 16'd1 : cfg_tpp;
            tick_ctr = tick_ctr + 16'd1;
            if (tick_ctr >= len) begin
                tick_ctr = 16'd0;
                fin      = close_phase(sda);
            end
        end
        return result_of(scl_q, sda_q, bus_seg != SEQ_IDLE, fin != FinNone, fin == FinFail,
                         {rx_hi, rx_lo});
    endfunction

    function automatic void add_row(input logic op, input logic [7:0] cmd, input logic sda,
                                    input bit typed, input res_t want);
        stim_row_t r;
        r.op    = op;
        r.cmd   = cmd;
        r.sda   = sda;
        r.typed = typed;
        r.want  = want;
        row_q.push_back(r);
    endfunction

    task automatic set_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            RegSlaveAddr:     cfg_addr  = val[6:0];
            RegTicksPerPhase: cfg_tpp   = val;
            RegMaxAttempts:   cfg_tries = val[7:0];
            default: ;
        endcase
    endtask

    // offer one item, then record what it must produce
    task automatic deliver(input logic op, input logic [7:0] cmd, input logic sda,
                           input bit typed, input res_t want);
        int unsigned gap;
        int unsigned roll;
        seq_t        prior;
        res_t        guess;
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, sda, cmd};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        prior = bus_seg;
        guess = master_step(op, cmd, sda);
        bus_results_q.push_back(typed ? want : guess);
        // new attempt: decide how the slave behaves in it
        if (bus_seg == SEQ_START1 && prior != SEQ_START1) begin
            roll = $urandom_range(0, 19);
            if (roll < 11)      plan_kind = PlanGood;
            else if (roll < 14) plan_kind = PlanBadPec;
            else if (roll < 17) plan_kind = PlanNack;
            else                plan_kind = PlanNoise;
            plan_lo  = 8'($urandom);
            plan_hi  = 8'($urandom);
            plan_pec = crc8_next(8'd0, {cfg_addr, 1'b0});
            plan_pec = crc8_next(plan_pec, cmd_hold);
            plan_pec = crc8_next(plan_pec, {cfg_addr, 1'b1});
            plan_pec = crc8_next(plan_pec, plan_lo);
            plan_pec = crc8_next(plan_pec, plan_hi);
            if (plan_kind == PlanBadPec) plan_pec = plan_pec ^ 8'($urandom_range(1, 255));
            case ($urandom_range(0, 2))
                0: plan_nack_at = SEQ_TX_ADDRW;
                1: plan_nack_at = SEQ_TX_CMD;
                default: plan_nack_at = SEQ_TX_ADDRR;
            endcase
        end
        @(negedge clk);
    endtask

    // stop offering and wait until every result is out
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (bus_results_q.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            fault_count++;
        end
    endtask

    initial
    begin : result_side
        int unsigned wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            wait_n = rx_gaps_on ? $urandom_range(0, 5) : 0;
            if (wait_n > 0) begin
                m_axis_tready = 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin : result_check
        res_t got;
        res_t want;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[20:0];
                if (bus_results_q.size() == 0) begin
                    $display("%0t ns: unexpected result item, expected none got %h",
                             $time, got);
                    fault_count++;
                end else begin
                    want = bus_results_q.pop_front();
                    check_field("scl_out", 16'(want.scl_out), 16'(got.scl_out));
                    check_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
                    check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                    check_field("failed", 16'(want.failed), 16'(got.failed));
                    check_field("read_word", want.read_word, got.read_word);
                end
            end
        end
    end

    initial
    begin : no_progress_guard
        int unsigned quiet;
        quiet = 0;
        while (quiet < NoAcceptLimit) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned work_items;
        int unsigned phase_no;
        int unsigned pick;
        logic        sda_pick;
        stim_row_t   row;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OpTick;
        cfg_we        = 1'b0;
        cfg_index     = RegSlaveAddr;
        cfg_data      = '0;
        fault_count   = 0;
        rx_hold       = 0;
        tx_gaps_on    = 1'b1;
        rx_gaps_on    = 1'b1;

        cfg_addr     = 7'd0;
        cfg_tpp      = 16'd8;
        cfg_tries    = 8'd255;
        bus_seg      = SEQ_IDLE;
        ph_ctr       = 0;
        tick_ctr     = 16'd0;
        bit_ctr      = 4'd0;
        shreg        = 8'd0;
        rx_lo        = 8'd0;
        rx_hi        = 8'd0;
        crc_acc      = 8'd0;
        tries_left   = 8'd0;
        cmd_hold     = 8'd0;
        nack_flag    = 1'b0;
        scl_q        = 1'b1;
        sda_q        = 1'b1;
        plan_kind    = PlanGood;
        plan_nack_at = SEQ_TX_ADDRW;
        plan_lo      = 8'd0;
        plan_hi      = 8'd0;
        plan_pec     = 8'd0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero phase length counts as one tick, zero attempts fails after the first stop
        set_reg(RegSlaveAddr, 16'h007F);
        set_reg(RegTicksPerPhase, 16'h0000);
        set_reg(RegMaxAttempts, 16'h0000);

        // idle ticks leave both lines released
        add_row(OpTick,    8'hFF, 1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'h00, 1'b0, 1'b1, result_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
        add_row(OpRequest, 8'hA5, 1'b0, 1'b1, result_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0));
        // request while busy is dropped
        add_row(OpRequest, 8'h5A, 1'b1, 1'b1, result_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'h00, 1'b1, 1'b1, result_of(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'hFF, 1'b0, 1'b1, result_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'h0F, 1'b1, 1'b1, result_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'hF0, 1'b0, 1'b1, result_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0));
        add_row(OpTick,    8'h00, 1'b0, 1'b1, result_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
        add_row(OpRequest, 8'hFF, 1'b1, 1'b1, result_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0));
        add_row(OpTick,    8'h81, 1'b0, 1'b0, '0);
        add_row(OpRequest, 8'h00, 1'b0, 1'b0, '0);
        add_row(OpTick,    8'h7E, 1'b1, 1'b0, '0);
        add_row(OpTick,    8'hC3, 1'b0, 1'b0, '0);
        add_row(OpTick,    8'h3C, 1'b1, 1'b0, '0);
        add_row(OpTick,    8'hAA, 1'b1, 1'b0, '0);
        add_row(OpRequest, 8'h00, 1'b0, 1'b0, '0);
        add_row(OpTick,    8'h55, 1'b0, 1'b0, '0);
        add_row(OpTick,    8'hFF, 1'b1, 1'b0, '0);
        add_row(OpTick,    8'h00, 1'b0, 1'b0, '0);
        add_row(OpTick,    8'h99, 1'b1, 1'b0, '0);
        add_row(OpTick,    8'h66, 1'b0, 1'b0, '0);
        while (row_q.size() != 0) begin
            row = row_q.pop_front();
            deliver(row.op, row.cmd, row.sda, row.typed, row.want);
        end
        settle();

        // longest phase length for a while, then shortened so the stop ends soon
        set_reg(RegTicksPerPhase, 16'hFFFF);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        deliver(OpRequest, 8'hFF, 1'b1, 1'b0, '0);
        repeat (40) deliver(OpTick, 8'($urandom), 1'($urandom), 1'b0, '0);
        settle();
        set_reg(RegTicksPerPhase, 16'h0001);
        while (bus_seg != SEQ_IDLE) deliver(OpTick, 8'($urandom), 1'($urandom), 1'b0, '0);
        settle();

        work_items = 0;
        phase_no   = 0;
        while (work_items < 1200) begin
            settle();
            if (phase_no % 4 == 0) begin
                pick = $urandom_range(0, 2);
                set_reg(RegSlaveAddr, (pick == 0) ? 16'd0 :
                                      (pick == 1) ? 16'd127 : 16'($urandom_range(0, 127)));
                set_reg(RegTicksPerPhase, 16'($urandom_range(0, 3)));
                pick = $urandom_range(0, 4);
                set_reg(RegMaxAttempts, (pick == 0) ? 16'd1 :
                                        (pick == 1) ? 16'd255 : 16'($urandom_range(0, 8)));
            end else begin
                // may land in the middle of a transaction
                case ($urandom_range(0, 2))
                    0: set_reg(RegSlaveAddr, 16'($urandom_range(0, 127)));
                    1: set_reg(RegTicksPerPhase, 16'($urandom_range(0, 3)));
                    default: set_reg(RegMaxAttempts, 16'($urandom_range(0, 8)));
                endcase
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 1) rx_hold = LongHold;
            repeat ($urandom_range(100, 400)) begin
                if (bus_seg == SEQ_IDLE) begin
                    if ($urandom_range(0, 3) == 0) begin
                        deliver(OpTick, 8'($urandom), 1'($urandom), 1'b0, '0);
                    end else begin
                        deliver(OpRequest, 8'($urandom), 1'($urandom), 1'b0, '0);
                        work_items++;
                    end
                end else if ($urandom_range(0, 49) == 0) begin
                    deliver(OpRequest, 8'($urandom), 1'($urandom), 1'b0, '0);
                end else begin
                    sda_pick = 1'($urandom);
                    if (plan_kind != PlanNoise) begin
                        if (is_tx(bus_seg) && bit_ctr == 8) begin
                            sda_pick = (plan_kind == PlanNack) && (bus_seg == plan_nack_at);
                        end else if (bit_ctr < 8) begin
                            case (bus_seg)
                                SEQ_RX_LOW:  sda_pick = plan_lo[3'(4'd7 - bit_ctr)];
                                SEQ_RX_HIGH: sda_pick = plan_hi[3'(4'd7 - bit_ctr)];
                                SEQ_RX_PEC:  sda_pick = plan_pec[3'(4'd7 - bit_ctr)];
                                default: ;
                            endcase
                        end
                    end
                    deliver(OpTick, 8'($urandom), sda_pick, 1'b0, '0);
                    work_items++;
                end
            end
            phase_no++;
        end

        settle();
        repeat (4) @(posedge clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== smbus_read_word_pec_master_core.f =====
rtl/smbrw_pkg.sv
rtl/smbrw_engine.sv
rtl/smbus_read_word_pec_master_core.sv
verif/testbench.sv
